>>> hdl/ipec_pkg.sv
// ----------------------------------------------------------------------------
// IMU posture event classifier package
// Shared types, arithmetic constants and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipec_pkg;

  localparam int unsigned RadPerDeg   = 36602;
  localparam int unsigned InvG        = 1710216;
  localparam int unsigned CordicX0    = 652032874;
  localparam int unsigned HalfPi      = 102944;
  localparam int unsigned PiQ16       = 205887;
  localparam int unsigned SqrtSteps   = 24;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepMax     = 999999;

  localparam logic [1:0] CFG_FALL   = 2'd0;
  localparam logic [1:0] CFG_IMPACT = 2'd1;
  localparam logic [1:0] CFG_STILL  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PR,
    OP_RR,
    OP_AX,
    OP_AY,
    OP_AZ,
    OP_N,
    OP_VC,
    OP_VS,
    OP_VG
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULA,
    S_WB,
    S_INIT,
    S_ITER,
    S_MULB,
    S_WB2,
    S_OUT
  } state_e;

  typedef struct packed {
    logic       load;
    op_e        op;
    logic       init;
    logic       iter;
    logic [4:0] idx;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic smp_valid;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0:    r = 16'd51472;
      4'd1:    r = 16'd30386;
      4'd2:    r = 16'd16055;
      4'd3:    r = 16'd8150;
      4'd4:    r = 16'd4091;
      4'd5:    r = 16'd2047;
      4'd6:    r = 16'd1024;
      4'd7:    r = 16'd512;
      4'd8:    r = 16'd256;
      4'd9:    r = 16'd128;
      4'd10:   r = 16'd64;
      4'd11:   r = 16'd32;
      4'd12:   r = 16'd16;
      4'd13:   r = 16'd8;
      4'd14:   r = 16'd4;
      default: r = 16'd2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ipec_ctrl.sv
// ----------------------------------------------------------------------------
// IMU posture event classifier controller
// Sequences the shared multiplier, the square root and the CORDIC steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ipec_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ipec_pkg::sts_t sts_i,
  output ipec_pkg::cmd_t     cmd_o
);

  ipec_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipec_pkg::S_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.op     = ipec_pkg::OP_NONE;
    cmd_o.idx    = cnt_q;
    unique case (state_q)
      ipec_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = 5'd0;
          state_d    = ipec_pkg::S_MULA;
        end
      end
      ipec_pkg::S_MULA: begin
        if (cnt_q == 5'd0 && !sts_i.smp_valid) begin
          state_d = ipec_pkg::S_OUT;
        end else begin
          case (cnt_q)
            5'd0:    cmd_o.op = ipec_pkg::OP_PR;
            5'd1:    cmd_o.op = ipec_pkg::OP_RR;
            5'd2:    cmd_o.op = ipec_pkg::OP_AX;
            5'd3:    cmd_o.op = ipec_pkg::OP_AY;
            default: cmd_o.op = ipec_pkg::OP_AZ;
          endcase
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd4) begin
            cnt_d   = 5'd0;
            state_d = ipec_pkg::S_WB;
          end
        end
      end
      ipec_pkg::S_WB: begin
        state_d = ipec_pkg::S_INIT;
      end
      ipec_pkg::S_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d      = 5'd0;
        state_d    = ipec_pkg::S_ITER;
      end
      ipec_pkg::S_ITER: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'(ipec_pkg::SqrtSteps - 1)) begin
          cnt_d   = 5'd0;
          state_d = ipec_pkg::S_MULB;
        end
      end
      ipec_pkg::S_MULB: begin
        case (cnt_q)
          5'd0:    cmd_o.op = ipec_pkg::OP_N;
          5'd1:    cmd_o.op = ipec_pkg::OP_VC;
          5'd2:    cmd_o.op = ipec_pkg::OP_VS;
          5'd3:    cmd_o.op = ipec_pkg::OP_NONE;
          default: cmd_o.op = ipec_pkg::OP_VG;
        endcase
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          cnt_d   = 5'd0;
          state_d = ipec_pkg::S_WB2;
        end
      end
      ipec_pkg::S_WB2: begin
        state_d = ipec_pkg::S_OUT;
      end
      ipec_pkg::S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ipec_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ipec_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/ipec_dp.sv
// ----------------------------------------------------------------------------
// IMU posture event classifier datapath
// Sample registers, shared multiplier, bit-serial square root, CORDIC,
// thresholds, edge state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipec_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ipec_pkg::cmd_t cmd_i,
  output ipec_pkg::sts_t      sts_o,
  input  wire logic [191:0]   in_data_i,
  input  wire logic           in_user_i,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [22:0]    cfg_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [87:0]         out_data_o,
  output logic [4:0]          out_user_o
);

  logic [13:0] fall_lim_q;
  logic [15:0] imp_lim_q;
  logic [22:0] still_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_lim_q  <= 14'd4096;
      imp_lim_q   <= 16'd8192;
      still_lim_q <= 23'd512;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ipec_pkg::CFG_FALL:   fall_lim_q  <= cfg_data_i[13:0];
        ipec_pkg::CFG_IMPACT: imp_lim_q   <= cfg_data_i[15:0];
        ipec_pkg::CFG_STILL:  still_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [15:0] roll_q, pitch_q;
  logic signed [23:0] gx_q, gy_q, gz_q;
  logic signed [19:0] ax_q, ay_q, az_q;
  logic [23:0] el_q;
  logic        vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      roll_q  <= in_data_i[15:0];
      pitch_q <= in_data_i[31:16];
      gx_q    <= in_data_i[55:32];
      gy_q    <= in_data_i[79:56];
      gz_q    <= in_data_i[103:80];
      ax_q    <= in_data_i[123:104];
      ay_q    <= in_data_i[143:124];
      az_q    <= in_data_i[163:144];
      el_q    <= in_data_i[187:164];
      vld_q   <= in_user_i;
    end
  end

  logic signed [32:0] x_q, y_q;
  logic signed [20:0] z_q;
  logic               neg_q;
  logic signed [32:0] sin_v, cos_v;
  logic [23:0]        root_q;
  logic signed [53:0] v_q;

  assign sin_v = neg_q ? -y_q : y_q;
  assign cos_v = neg_q ? -x_q : x_q;

  logic signed [39:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [63:0] prod_q;
  ipec_pkg::op_e      op_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      ipec_pkg::OP_PR: begin
        mul_a = 40'(ipec_pkg::RadPerDeg);
        mul_b = {{8{pitch_q[15]}}, pitch_q};
      end
      ipec_pkg::OP_RR: begin
        mul_a = 40'(ipec_pkg::RadPerDeg);
        mul_b = {{8{roll_q[15]}}, roll_q};
      end
      ipec_pkg::OP_AX: begin
        mul_a = {{20{ax_q[19]}}, ax_q};
        mul_b = {{4{ax_q[19]}}, ax_q};
      end
      ipec_pkg::OP_AY: begin
        mul_a = {{20{ay_q[19]}}, ay_q};
        mul_b = {{4{ay_q[19]}}, ay_q};
      end
      ipec_pkg::OP_AZ: begin
        mul_a = {{20{az_q[19]}}, az_q};
        mul_b = {{4{az_q[19]}}, az_q};
      end
      ipec_pkg::OP_N: begin
        mul_a = {16'd0, root_q};
        mul_b = 24'(ipec_pkg::InvG);
      end
      ipec_pkg::OP_VC: begin
        mul_a = {{7{cos_v[32]}}, cos_v};
        mul_b = {{4{az_q[19]}}, az_q};
      end
      ipec_pkg::OP_VS: begin
        mul_a = {{7{sin_v[32]}}, sin_v};
        mul_b = {{4{ax_q[19]}}, ax_q};
      end
      ipec_pkg::OP_VG: begin
        mul_a = v_q[53:14];
        mul_b = 24'(ipec_pkg::InvG);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= ipec_pkg::OP_NONE;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  logic signed [63:0] rnd;
  logic signed [63:0] wb_sum;
  logic signed [15:0] pr_q, rr_q;
  logic [39:0]        sq_q;
  logic [18:0]        n_q;
  logic signed [25:0] vg_q;

  always_comb begin
    case (op_q)
      ipec_pkg::OP_PR, ipec_pkg::OP_RR: rnd = 64'sd32768;
      ipec_pkg::OP_N:                   rnd = 64'sd1 <<< 25;
      ipec_pkg::OP_VG:                  rnd = 64'sd1 <<< 37;
      default:                          rnd = '0;
    endcase
  end

  assign wb_sum = prod_q + rnd;

  always_ff @(posedge clk_i) begin
    case (op_q)
      ipec_pkg::OP_PR: pr_q <= wb_sum[31:16];
      ipec_pkg::OP_RR: rr_q <= wb_sum[31:16];
      ipec_pkg::OP_AX: sq_q <= prod_q[39:0];
      ipec_pkg::OP_AY: sq_q <= sq_q + prod_q[39:0];
      ipec_pkg::OP_AZ: sq_q <= sq_q + prod_q[39:0];
      ipec_pkg::OP_N:  n_q  <= wb_sum[44:26];
      ipec_pkg::OP_VC: v_q  <= prod_q[53:0];
      ipec_pkg::OP_VS: v_q  <= v_q + prod_q[53:0];
      ipec_pkg::OP_VG: vg_q <= wb_sum[63:38];
      default: ;
    endcase
  end

  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [27:0] rem_sh, trial;

  assign rem_sh = {rem_q, rad_q[47:46]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      rad_q  <= {sq_q, 8'd0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.iter) begin
      rad_q <= {rad_q[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 26'(rem_sh - trial);
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[25:0];
        root_q <= {root_q[22:0], 1'b0};
      end
    end
  end

  logic signed [20:0] z0;
  logic [3:0]         ci;
  logic signed [20:0] at;

  assign z0 = {pr_q[15], pr_q, 4'b0000};
  assign ci = cmd_i.idx[3:0];
  assign at = {5'd0, ipec_pkg::atan_q16(ci)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      x_q <= 33'(ipec_pkg::CordicX0);
      y_q <= '0;
      if (z0 > 21'sd102944) begin
        z_q   <= z0 - 21'(ipec_pkg::PiQ16);
        neg_q <= 1'b1;
      end else if (z0 < -21'sd102944) begin
        z_q   <= z0 + 21'(ipec_pkg::PiQ16);
        neg_q <= 1'b1;
      end else begin
        z_q   <= z0;
        neg_q <= 1'b0;
      end
    end else if (cmd_i.iter && cmd_i.idx < 5'(ipec_pkg::CordicSteps)) begin
      if (z_q >= 0) begin
        x_q <= x_q - (y_q >>> ci);
        y_q <= y_q + (x_q >>> ci);
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + (y_q >>> ci);
        y_q <= y_q - (x_q >>> ci);
        z_q <= z_q + at;
      end
    end
  end

  logic [15:0] pr_abs, rr_abs;
  logic [23:0] gx_abs, gy_abs, gz_abs;
  logic        fallen, impact, still;
  logic [15:0] norm_sat, vg_sat;
  logic [19:0] step;

  assign pr_abs = pr_q[15] ? 16'(-pr_q) : pr_q;
  assign rr_abs = rr_q[15] ? 16'(-rr_q) : rr_q;
  assign gx_abs = gx_q[23] ? 24'(-gx_q) : gx_q;
  assign gy_abs = gy_q[23] ? 24'(-gy_q) : gy_q;
  assign gz_abs = gz_q[23] ? 24'(-gz_q) : gz_q;

  assign fallen = (pr_abs > {2'b00, fall_lim_q}) || (rr_abs > {2'b00, fall_lim_q});
  assign impact = n_q > {3'd0, imp_lim_q};
  assign still  = (gx_abs < {1'b0, still_lim_q}) && (gy_abs < {1'b0, still_lim_q})
               && (gz_abs < {1'b0, still_lim_q});
  assign norm_sat = (n_q > 19'd65535) ? 16'hFFFF : n_q[15:0];

  always_comb begin
    if (vg_q > 26'sd32767) begin
      vg_sat = 16'h7FFF;
    end else if (vg_q < -26'sd32768) begin
      vg_sat = 16'h8000;
    end else begin
      vg_sat = vg_q[15:0];
    end
  end

  assign step = (el_q != 24'd0 && el_q <= 24'(ipec_pkg::StepMax)) ? el_q[19:0] : 20'd0;

  logic prev_fall_q, prev_imp_q;
  logic out_valid_q;
  logic [87:0] out_data_q;
  logic [4:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_fall_q <= 1'b0;
      prev_imp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (vld_q) begin
          prev_fall_q <= fallen;
          prev_imp_q  <= impact;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (vld_q) begin
        out_data_q <= {4'd0, vg_sat, norm_sat, rr_q, pr_q, step};
        out_user_q <= {impact & ~prev_imp_q, fallen & ~prev_fall_q, still, impact, fallen};
      end else begin
        out_data_q <= {68'd0, step};
        out_user_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_user_o      = out_user_q;
  assign sts_o.smp_valid = vld_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  a_fall_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_user_q[3] && !out_user_q[0]))
    else $error("fall event without fallen");

  a_imp_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_user_q[4] && !out_user_q[1]))
    else $error("impact event without impact");

  a_edge_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !vld_q) |=> ($stable(prev_fall_q) && $stable(prev_imp_q)))
    else $error("edge state changed on invalid sample");

endmodule

`default_nettype wire

>>> hdl/imu_posture_event_classifier.sv
// ----------------------------------------------------------------------------
// IMU posture event classifier
// An invalid sample skips the arithmetic and goes straight to the output.
// A new sample is taken only after the last result is registered, so a
// stalled output holds the input back; the schedule is set by the 24-step
// bit-serial square root that shares it with the CORDIC. Reset clears the
// controller, edge state and output valid, and loads the default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_posture_event_classifier (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // Roll, pitch, gyro x, gyro y, gyro z, accel x, accel y, accel z,
  // elapsed microseconds, zero padding.
  input  wire logic [191:0] s_axis_tdata_i,
  // sample_valid.
  input  wire logic         s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // Step interval, pitch, roll, acceleration norm, vertical_g, zero padding.
  output logic [87:0]       m_axis_tdata_o,
  // fallen, impact, stationary, fall_event, impact_event.
  output logic [4:0]        m_axis_tuser_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [22:0]  cfg_data_i
);

  ipec_pkg::cmd_t cmd;
  ipec_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ipec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire
